>>> rtl/core/lru_pkg.sv
// Shared constants and types for the LRU page replacement block.
package lru_pkg;

  localparam int FRAMES     = 8;
  localparam int PAGE_BITS  = 16;
  localparam int STAMP_BITS = 32;
  localparam int FAULT_BITS = 32;
  localparam int IDX_W      = $clog2(FRAMES);
  localparam int CNT_W      = 4;

  typedef logic [IDX_W-1:0]      frame_idx_t;
  typedef logic [PAGE_BITS-1:0]  page_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;

  // Write port of the frame table.
  typedef struct packed {
    logic       en;
    frame_idx_t idx;
    page_t      page;
    stamp_t     stamp;
  } frame_wr_t;

  // Contents of one frame.
  typedef struct packed {
    logic   valid;
    page_t  page;
    stamp_t stamp;
  } frame_rd_t;

endpackage

>>> rtl/core/lru_frame_store.sv
// Frame table: valid bits, page numbers and last-use stamps.
module lru_frame_store import lru_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  frame_wr_t  wr,
  input  frame_idx_t rd_idx,
  output frame_rd_t  rd
);

  logic [FRAMES-1:0] valid_r;
  page_t             page_r  [FRAMES];
  stamp_t            stamp_r [FRAMES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      page_r[wr.idx]  <= wr.page;
      stamp_r[wr.idx] <= wr.stamp;
    end
  end

  assign rd.valid = valid_r[rd_idx];
  assign rd.page  = page_r[rd_idx];
  assign rd.stamp = stamp_r[rd_idx];

endmodule

>>> rtl/core/lru_page_replacement.sv
// Top level: LRU page replacement with a frame scan sequencer.
//
//   channel | direction | handshake       | payload
//   in_     | input     | in_valid/stall  | page_number
//   out_    | output    | out_valid/stall | hit, frame_index, evicted_valid,
//           |           |                 | evicted_page, fault_total
//   cfg_    | input     | cfg_valid/ready | frames_in_use
//
// For each item one compare unit visits the frames in use, clamped to the
// table, one frame per cycle, looking for a hit, the first empty frame and
// the smallest stamp; a commit step then follows.
// Reset (synchronous, active low) empties all frames, clears the use clock and
// the fault count, and sets frames in use to eight. A stalled result holds
// the commit; the next item is still taken while a result waits.
module lru_page_replacement import lru_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [15:0]       in_page_number,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_hit,
  output logic [2:0]        out_frame_index,
  output logic              out_evicted_valid,
  output logic [15:0]       out_evicted_page,
  output logic [31:0]       out_fault_total,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_frames_in_use
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_COMMIT} state_t;

  state_t                state_r;
  logic [CNT_W-1:0]      frames_in_use_r;
  page_t                 page_r;
  frame_idx_t            scan_idx_r;
  frame_idx_t            last_idx_r;
  logic                  found_r;
  frame_idx_t            hit_idx_r;
  logic                  empty_r;
  frame_idx_t            empty_idx_r;
  stamp_t                best_stamp_r;
  frame_idx_t            best_idx_r;
  page_t                 best_page_r;
  stamp_t                use_clock_r;
  logic [FAULT_BITS-1:0] fault_count_r;
  logic                  out_valid_r;
  logic                  out_hit_r;
  frame_idx_t            out_idx_r;
  logic                  out_ev_valid_r;
  page_t                 out_ev_page_r;
  logic [FAULT_BITS-1:0] out_fault_r;

  frame_wr_t             wr;
  frame_rd_t             rd;
  stamp_t                clock_nxt;
  logic [FAULT_BITS-1:0] fault_nxt;
  frame_idx_t            slot_nxt;
  frame_idx_t            last_idx_nxt;
  logic                  in_accept;
  logic                  commit_go;

  lru_frame_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .rd_idx (scan_idx_r),
    .rd     (rd)
  );

  assign in_accept = in_valid && !in_stall;
  assign commit_go = (state_r == ST_COMMIT) && (!out_valid_r || !out_stall);
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Zero acts as one frame, anything above the table size as the full table.
  always_comb begin
    if (frames_in_use_r == '0) begin
      last_idx_nxt = '0;
    end else if (frames_in_use_r > CNT_W'(FRAMES)) begin
      last_idx_nxt = IDX_W'(FRAMES - 1);
    end else begin
      last_idx_nxt = IDX_W'(frames_in_use_r - CNT_W'(1));
    end
  end

  always_comb begin
    clock_nxt = (use_clock_r == '1) ? use_clock_r : use_clock_r + STAMP_BITS'(1);
    if (found_r || fault_count_r == '1) begin
      fault_nxt = fault_count_r;
    end else begin
      fault_nxt = fault_count_r + FAULT_BITS'(1);
    end
    priority if (found_r) begin
      slot_nxt = hit_idx_r;
    end else if (empty_r) begin
      slot_nxt = empty_idx_r;
    end else begin
      slot_nxt = best_idx_r;
    end
  end

  always_comb begin
    wr.en    = commit_go;
    wr.idx   = slot_nxt;
    wr.page  = page_r;
    wr.stamp = clock_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      frames_in_use_r <= CNT_W'(FRAMES);
      use_clock_r     <= '0;
      fault_count_r   <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frames_in_use_r <= cfg_frames_in_use;
      end
      // A commit in the same cycle reloads the result register instead.
      if (out_valid_r && !out_stall && !commit_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            page_r     <= in_page_number;
            scan_idx_r <= '0;
            last_idx_r <= last_idx_nxt;
            found_r    <= 1'b0;
            empty_r    <= 1'b0;
            state_r    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd.valid && rd.page == page_r && !found_r) begin
            found_r   <= 1'b1;
            hit_idx_r <= scan_idx_r;
          end
          if (!rd.valid && !empty_r) begin
            empty_r     <= 1'b1;
            empty_idx_r <= scan_idx_r;
          end
          // Strict less-than keeps the lowest index on equal stamps.
          if (scan_idx_r == '0 || rd.stamp < best_stamp_r) begin
            best_stamp_r <= rd.stamp;
            best_idx_r   <= scan_idx_r;
            best_page_r  <= rd.page;
          end
          if (scan_idx_r == last_idx_r) begin
            state_r <= ST_COMMIT;
          end else begin
            scan_idx_r <= scan_idx_r + IDX_W'(1);
          end
        end
        ST_COMMIT: begin
          if (commit_go) begin
            use_clock_r    <= clock_nxt;
            fault_count_r  <= fault_nxt;
            out_valid_r    <= 1'b1;
            out_hit_r      <= found_r;
            out_idx_r      <= slot_nxt;
            out_ev_valid_r <= !found_r && !empty_r;
            out_ev_page_r  <= (!found_r && !empty_r) ? best_page_r : '0;
            out_fault_r    <= fault_nxt;
            state_r        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_index   = out_idx_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_total   = out_fault_r;

endmodule
